// File: rtl/vfp_pkg.sv
// ---------------------------------------------------------------------------
// vfp_pkg
// Shared types, codes and the system register field map of the FP register
// file.
// ---------------------------------------------------------------------------
`default_nettype none

package vfp_pkg;

   localparam int NUM_DOUBLES  = 16;
   localparam int DBL_IDX_W    = $clog2(NUM_DOUBLES);
   localparam int DATA_W       = 64;
   localparam int WORD_W       = 32;
   localparam int INDEX_W      = 5;
   localparam int VLEN_W       = 3;

   localparam int REQ_TDATA_W  = 72;
   localparam int REQ_TUSER_W  = 4;
   localparam int RSP_TDATA_W  = 72;
   localparam int RSP_TUSER_W  = 1;
   localparam int RSP_PAD_W    = RSP_TDATA_W - DATA_W - VLEN_W;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CFG_IMPLEMENTOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_FORMAT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_PRECISION   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CFG_ARCH        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CFG_PART        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CFG_VARIANT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CFG_REVISION    = 3'd6;

   localparam logic [3:0] ARCH_RESET = 4'd1;

   // precision support codes
   localparam logic [1:0] PREC_BOTH   = 2'd0;
   localparam logic [1:0] PREC_SINGLE = 2'd1;

   // register spaces
   localparam logic [1:0] SPACE_SINGLE = 2'd0;
   localparam logic [1:0] SPACE_DOUBLE = 2'd1;
   localparam logic [1:0] SPACE_SYSTEM = 2'd2;

   localparam logic [INDEX_W-1:0] SYS_CODE_INVALID = 5'd31;

   // exception word control bits and the ID register single-precision bit
   localparam int EXC_EX_BIT = 31;
   localparam int EXC_EN_BIT = 30;
   localparam int ID_SNG_BIT = 20;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_SETUP = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      SYS_ID = 2'd0,
      SYS_SC = 2'd1,
      SYS_EX = 2'd2
   } sys_reg_type;

   typedef struct packed {
      sys_reg_type       which;
      logic [4:0]        lo;
      logic [WORD_W-1:0] mask;
   } sys_field_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } vfp_cmd_type;

   function automatic sys_field_type sys_lookup(input logic [INDEX_W-1:0] code);
      sys_field_type f;
      unique case (code)
         5'd0:  f = '{SYS_ID, 5'd0,  32'hFFFF_FFFF};
         5'd1:  f = '{SYS_ID, 5'd24, 32'h0000_00FF};
         5'd2:  f = '{SYS_ID, 5'd23, 32'h0000_0001};
         5'd3:  f = '{SYS_ID, 5'd21, 32'h0000_0003};
         5'd4:  f = '{SYS_ID, 5'd20, 32'h0000_0001};
         5'd5:  f = '{SYS_ID, 5'd16, 32'h0000_000F};
         5'd6:  f = '{SYS_ID, 5'd8,  32'h0000_00FF};
         5'd7:  f = '{SYS_ID, 5'd4,  32'h0000_000F};
         5'd8:  f = '{SYS_ID, 5'd0,  32'h0000_000F};
         5'd9:  f = '{SYS_SC, 5'd0,  32'hFFFF_FFFF};
         5'd10: f = '{SYS_SC, 5'd31, 32'h0000_0001};
         5'd11: f = '{SYS_SC, 5'd30, 32'h0000_0001};
         5'd12: f = '{SYS_SC, 5'd29, 32'h0000_0001};
         5'd13: f = '{SYS_SC, 5'd28, 32'h0000_0001};
         5'd14: f = '{SYS_SC, 5'd24, 32'h0000_0001};
         5'd15: f = '{SYS_SC, 5'd22, 32'h0000_0003};
         5'd16: f = '{SYS_SC, 5'd20, 32'h0000_0003};
         5'd17: f = '{SYS_SC, 5'd16, 32'h0000_0007};
         5'd18: f = '{SYS_SC, 5'd12, 32'h0000_0001};
         5'd19: f = '{SYS_SC, 5'd11, 32'h0000_0001};
         5'd20: f = '{SYS_SC, 5'd10, 32'h0000_0001};
         5'd21: f = '{SYS_SC, 5'd9,  32'h0000_0001};
         5'd22: f = '{SYS_SC, 5'd8,  32'h0000_0001};
         5'd23: f = '{SYS_SC, 5'd4,  32'h0000_0001};
         5'd24: f = '{SYS_SC, 5'd3,  32'h0000_0001};
         5'd25: f = '{SYS_SC, 5'd2,  32'h0000_0001};
         5'd26: f = '{SYS_SC, 5'd1,  32'h0000_0001};
         5'd27: f = '{SYS_SC, 5'd0,  32'h0000_0001};
         5'd28: f = '{SYS_EX, 5'd0,  32'hFFFF_FFFF};
         5'd29: f = '{SYS_EX, 5'd31, 32'h0000_0001};
         5'd30: f = '{SYS_EX, 5'd30, 32'h0000_0001};
         default: f = '{SYS_EX, 5'd0, 32'h0000_0000};
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// File: rtl/vfp_register_file_core.sv
// ---------------------------------------------------------------------------
// vfp_register_file_core
// FP register file with single/double aliasing and ID, status and exception
// system registers.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req_*     in         req_tvalid/tready     tuser: type, space; tdata: index, value
//  rsp_*     out        rsp_tvalid/tready     tdata: read data, length; tuser: bad
//  csr_*     in         csr_valid/csr_ready   csr_index, csr_data
//
//  Each transaction steps through capture, execute and respond, and waits out
//  any response stall, as stepped by the sequencer in vfp_ctrl.
//  One transaction is in flight at a time; req_tready is low until the
//  response is taken.
//  Synchronous reset clears the bank and the system registers and loads the
//  configuration defaults; csr_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module vfp_register_file_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // [4:0] reg_index, [68:5] write_value, [71:69] zero
   input  wire  [vfp_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // [1:0] req_type, [3:2] reg_space
   input  wire  [vfp_pkg::REQ_TUSER_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [63:0] read_data, [66:64] vector_length, [71:67] zero
   output logic [vfp_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // [0] bad_target
   output logic [vfp_pkg::RSP_TUSER_W-1:0]       rsp_tuser,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [vfp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [vfp_pkg::CSR_DATA_W-1:0]        csr_data
);

   vfp_pkg::vfp_cmd_type             cmd;
   logic [vfp_pkg::DATA_W-1:0]       read_data;
   logic [vfp_pkg::VLEN_W-1:0]       vector_length;
   logic                             bad_target;

   assign csr_ready = 1'b1;

   vfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   vfp_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_tuser[1:0]),
      .reg_space     (req_tuser[3:2]),
      .reg_index     (req_tdata[vfp_pkg::INDEX_W-1:0]),
      .write_value   (req_tdata[vfp_pkg::INDEX_W +: vfp_pkg::DATA_W]),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .read_data     (read_data),
      .vector_length (vector_length),
      .bad_target    (bad_target)
   );

   assign rsp_tdata = {{vfp_pkg::RSP_PAD_W{1'b0}}, vector_length, read_data};
   assign rsp_tuser = bad_target;

endmodule

`default_nettype wire

// File: rtl/vfp_ctrl.sv
// ---------------------------------------------------------------------------
// vfp_ctrl
// Sequencer: capture a request, execute it in the datapath, hold the response.
// ---------------------------------------------------------------------------
`default_nettype none

module vfp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output vfp_pkg::vfp_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;
   logic      execute_ff;
   logic      accept;

   assign accept      = req_tvalid && req_tready_ff;
   assign req_tready  = req_tready_ff;
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign cmd.capture = accept;
   assign cmd.execute = execute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
         execute_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff      <= ST_EXEC;
                  req_tready_ff <= 1'b0;
                  execute_ff    <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff      <= ST_DONE;
               execute_ff    <= 1'b0;
               rsp_tvalid_ff <= 1'b1;
            end
            ST_DONE: begin
               if (rsp_tready) begin
                  state_ff      <= ST_IDLE;
                  rsp_tvalid_ff <= 1'b0;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= ST_IDLE;
               req_tready_ff <= 1'b1;
               rsp_tvalid_ff <= 1'b0;
               execute_ff    <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/vfp_dpath.sv
// ---------------------------------------------------------------------------
// vfp_dpath
// Double bank, system registers, configuration registers and result holding.
// ---------------------------------------------------------------------------
`default_nettype none

module vfp_dpath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  vfp_pkg::vfp_cmd_type                 cmd,
   input  wire  [1:0]                           req_type,
   input  wire  [1:0]                           reg_space,
   input  wire  [vfp_pkg::INDEX_W-1:0]          reg_index,
   input  wire  [vfp_pkg::DATA_W-1:0]           write_value,
   input  wire                                  csr_write,
   input  wire  [vfp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [vfp_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic [vfp_pkg::DATA_W-1:0]           read_data,
   output logic [vfp_pkg::VLEN_W-1:0]           vector_length,
   output logic                                 bad_target
);

   // latched request
   vfp_pkg::req_kind_type                kind_ff;
   logic [1:0]                           space_ff;
   logic [vfp_pkg::INDEX_W-1:0]          index_ff;
   logic [vfp_pkg::DATA_W-1:0]           wval_ff;

   // configuration
   logic [7:0] impl_ff;
   logic [1:0] format_ff;
   logic [1:0] prec_ff;
   logic [3:0] arch_ff;
   logic [7:0] part_ff;
   logic [3:0] variant_ff;
   logic [3:0] rev_ff;

   // architectural state
   logic [vfp_pkg::DATA_W-1:0] bank_ff [vfp_pkg::NUM_DOUBLES];
   logic [vfp_pkg::WORD_W-1:0] id_ff, id_in;
   logic [vfp_pkg::WORD_W-1:0] sc_ff, sc_in;
   logic [vfp_pkg::WORD_W-1:0] exc_ff, exc_in;

   logic [vfp_pkg::DATA_W-1:0] read_data_ff, read_data_in;
   logic                       bad_ff, bad_in;

   logic [vfp_pkg::DBL_IDX_W-1:0] dbl_sel;
   logic [vfp_pkg::DATA_W-1:0]    dbl_cur;
   logic [vfp_pkg::DATA_W-1:0]    bank_wdata;
   logic                          bank_wr;
   logic                          bank_clear;
   vfp_pkg::sys_field_type        fld;
   logic [vfp_pkg::WORD_W-1:0]    sys_cur;
   logic [vfp_pkg::WORD_W-1:0]    sys_get;
   logic [vfp_pkg::WORD_W-1:0]    sys_put;
   logic                          sng_bit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= vfp_pkg::req_kind_type'(req_type);
         space_ff <= reg_space;
         index_ff <= reg_index;
         wval_ff  <= write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         impl_ff    <= '0;
         format_ff  <= '0;
         prec_ff    <= '0;
         arch_ff    <= vfp_pkg::ARCH_RESET;
         part_ff    <= '0;
         variant_ff <= '0;
         rev_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            vfp_pkg::CFG_IMPLEMENTOR: impl_ff    <= csr_data;
            vfp_pkg::CFG_FORMAT:      format_ff  <= csr_data[1:0];
            vfp_pkg::CFG_PRECISION:   prec_ff    <= csr_data[1:0];
            vfp_pkg::CFG_ARCH:        arch_ff    <= csr_data[3:0];
            vfp_pkg::CFG_PART:        part_ff    <= csr_data;
            vfp_pkg::CFG_VARIANT:     variant_ff <= csr_data[3:0];
            vfp_pkg::CFG_REVISION:    rev_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dbl_sel = (space_ff == vfp_pkg::SPACE_SINGLE) ?
                index_ff[vfp_pkg::DBL_IDX_W:1] : index_ff[vfp_pkg::DBL_IDX_W-1:0];
      dbl_cur = bank_ff[dbl_sel];
      fld     = vfp_pkg::sys_lookup(index_ff);
      unique case (fld.which)
         vfp_pkg::SYS_ID: sys_cur = id_ff;
         vfp_pkg::SYS_SC: sys_cur = sc_ff;
         default:         sys_cur = exc_ff;
      endcase
      sys_get = (sys_cur >> fld.lo) & fld.mask;
      sys_put = (sys_cur & ~(fld.mask << fld.lo)) |
                ((wval_ff[vfp_pkg::WORD_W-1:0] & fld.mask) << fld.lo);
      if (prec_ff == vfp_pkg::PREC_BOTH) begin
         sng_bit = 1'b0;
      end else if (prec_ff == vfp_pkg::PREC_SINGLE) begin
         sng_bit = 1'b1;
      end else begin
         sng_bit = id_ff[vfp_pkg::ID_SNG_BIT];
      end
   end

   always_comb begin
      id_in        = id_ff;
      sc_in        = sc_ff;
      exc_in       = exc_ff;
      read_data_in = '0;
      bad_in       = 1'b0;
      bank_wr      = 1'b0;
      bank_clear   = 1'b0;
      bank_wdata   = dbl_cur;
      unique case (kind_ff)
         vfp_pkg::REQ_SETUP: begin
            exc_in[vfp_pkg::EXC_EN_BIT] = 1'b1;
            exc_in[vfp_pkg::EXC_EX_BIT] = 1'b0;
            sc_in = '0;
            id_in = {impl_ff, 1'b0, format_ff, sng_bit, arch_ff, part_ff, variant_ff, rev_ff};
         end
         vfp_pkg::REQ_CLEAR: begin
            bank_clear = 1'b1;
            exc_in[vfp_pkg::EXC_EN_BIT] = 1'b0;
         end
         vfp_pkg::REQ_READ, vfp_pkg::REQ_WRITE: begin
            unique case (space_ff)
               vfp_pkg::SPACE_SINGLE: begin
                  if (kind_ff == vfp_pkg::REQ_READ) begin
                     read_data_in = index_ff[0] ? {32'b0, dbl_cur[63:32]} :
                                                  {32'b0, dbl_cur[31:0]};
                  end else begin
                     bank_wr    = 1'b1;
                     bank_wdata = index_ff[0] ? {wval_ff[31:0], dbl_cur[31:0]} :
                                                {dbl_cur[63:32], wval_ff[31:0]};
                  end
               end
               vfp_pkg::SPACE_DOUBLE: begin
                  if (index_ff[vfp_pkg::DBL_IDX_W]) begin
                     bad_in = 1'b1;
                  end else if (kind_ff == vfp_pkg::REQ_READ) begin
                     read_data_in = dbl_cur;
                  end else begin
                     bank_wr    = 1'b1;
                     bank_wdata = wval_ff;
                  end
               end
               vfp_pkg::SPACE_SYSTEM: begin
                  if (index_ff == vfp_pkg::SYS_CODE_INVALID) begin
                     bad_in = 1'b1;
                  end else if (kind_ff == vfp_pkg::REQ_READ) begin
                     read_data_in = {32'b0, sys_get};
                  end else begin
                     unique case (fld.which)
                        vfp_pkg::SYS_ID: id_in  = sys_put;
                        vfp_pkg::SYS_SC: sc_in  = sys_put;
                        default:         exc_in = sys_put;
                     endcase
                  end
               end
               default: bad_in = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vfp_pkg::NUM_DOUBLES; i++) begin
            bank_ff[i] <= '0;
         end
         id_ff  <= '0;
         sc_ff  <= '0;
         exc_ff <= '0;
      end else if (cmd.execute) begin
         for (int i = 0; i < vfp_pkg::NUM_DOUBLES; i++) begin
            if (bank_clear) begin
               bank_ff[i] <= '0;
            end else if (bank_wr && (dbl_sel == vfp_pkg::DBL_IDX_W'(i))) begin
               bank_ff[i] <= bank_wdata;
            end
         end
         id_ff  <= id_in;
         sc_ff  <= sc_in;
         exc_ff <= exc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         read_data_ff <= read_data_in;
         bad_ff       <= bad_in;
      end
   end

   assign read_data     = read_data_ff;
   assign bad_target    = bad_ff;
   assign vector_length = sc_ff[18:16];

endmodule

`default_nettype wire
